// File: hdl/wav_pkg.sv
// Package: types, codes and helpers for the WAV PCM stream decoder.
package wav_pkg;

  typedef enum logic [3:0] {
    PH_RIFF_ID    = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_ID    = 4'd2,
    PH_CHUNK_ID   = 4'd3,
    PH_FMT_SIZE   = 4'd4,
    PH_DATA_SIZE  = 4'd5,
    PH_OTHER_SIZE = 4'd6,
    PH_FMT_BODY   = 4'd7,
    PH_SKIP       = 4'd8,
    PH_SAMPLES    = 4'd9,
    PH_IDLE       = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_RIFF_WAVE = 4'd1,
    ERR_RIFF_SIZE = 4'd2,
    ERR_SHORT_FMT = 4'd3,
    ERR_SKIP_END  = 4'd4,
    ERR_NOT_PCM   = 4'd5,
    ERR_RATE      = 4'd6,
    ERR_BITS      = 4'd7,
    ERR_CHANNELS  = 4'd8,
    ERR_ALIGN     = 4'd9,
    ERR_DATA_SIZE = 4'd10,
    ERR_TRUNCATED = 4'd11,
    ERR_DATA_EARLY= 4'd12,
    ERR_MISSING   = 4'd13
  } err_e;

  localparam logic [1:0] CFG_FILE_SIZE = 2'd0;
  localparam logic [1:0] CFG_RATE      = 2'd1;
  localparam logic [1:0] CFG_VOLUME    = 2'd2;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic        last_frame;
    logic [1:0]  channel_count;
    logic [3:0]  error_code;
  } out_t;

  // Product (33-bit signed) to Q15 sample: divide toward zero, saturate.
  function automatic logic [15:0] q15_sat(input logic signed [32:0] p);
    logic signed [32:0] q;
    begin
      q = (p < 0) ? -((-p) >>> 15) : (p >>> 15);
      if (q > 33'sd32767)       q15_sat = 16'h7FFF;
      else if (q < -33'sd32768) q15_sat = 16'h8000;
      else                      q15_sat = q[15:0];
    end
  endfunction

endpackage

// File: hdl/wav_stream_if.sv
// Interface: valid/ready channel carrying one payload word.
interface wav_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/wav_pcm_stream_decoder.sv
// Top level: byte-serial RIFF/WAVE PCM16 parser with Q15 volume scaling.
//
// Usage: bytes of a WAV file enter on in_ch, one transaction per byte, with
// start_of_file set on the first byte of each file. Results leave on out_ch:
// a header-accepted record once the data chunk header is checked, one
// stereo frame per complete sample frame (mono duplicated), or an error
// record, after which bytes are swallowed until the next start_of_file.
// Configuration (file size, expected rate, volume) is written through the
// cfg_we_i/cfg_idx_i/cfg_wdata_i port while the block is idle.
// A byte's scaling products are registered in the stage-1 register as the
// byte is accepted; the result then enters the output queue and can leave.
// Throughput: one byte per cycle while in_ch.ready is high; a two-entry
// output queue behind the stage-1 product register lets input keep flowing
// while the sink stalls. in_ch.ready drops only when both entries could fill.
// Reset clears all parse state, empties the pipeline and loads register
// defaults (file size 0, rate 44100, volume 32768).
module wav_pcm_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  wav_stream_if.sink   in_ch,
  wav_stream_if.source out_ch
);
  import wav_pkg::*;

  // configuration registers
  logic [31:0] file_size_q;
  logic [18:0] exp_rate_q;
  logic [15:0] volume_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      exp_rate_q  <= 19'd44100;
      volume_q    <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILE_SIZE: file_size_q <= cfg_wdata_i;
        CFG_RATE:      exp_rate_q  <= cfg_wdata_i[18:0];
        CFG_VOLUME:    volume_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // parse state
  phase_e      phase_q, phase_d;
  logic [4:0]  bif_q, bif_d;
  logic [31:0] shift_q, shift_d;
  logic [32:0] chunk_q, chunk_d;
  logic [31:0] pos_q, pos_d;
  logic [32:0] riff_end_q, riff_end_d;
  logic [15:0] fmt_code_q, fmt_code_d, chans_q, chans_d;
  logic [31:0] hrate_q, hrate_d, hbrate_q, hbrate_d;
  logic [15:0] halign_q, halign_d, hbits_q, hbits_d;
  logic        fseen_q, fseen_d;
  logic [31:0] dleft_q, dleft_d;
  logic [15:0] hleft_q, hleft_d;
  logic [7:0]  lowb_q, lowb_d;

  // stage 1 result (pre-scaling)
  logic        s1_vld_q, s1_vld_d;
  logic [1:0]  s1_kind_q, s1_kind_d;
  logic        s1_mono_q, s1_mono_d;
  logic        s1_last_q, s1_last_d;
  logic [1:0]  s1_ch_q, s1_ch_d;
  logic [3:0]  s1_err_q, s1_err_d;
  logic signed [32:0] s1_pl_q, s1_pr_q, s1_pl_d, s1_pr_d;

  // output queue
  out_t        fifo_q [2];
  logic        rd_ptr_q, wr_ptr_q;
  logic [1:0]  cnt_q;

  logic   accept;
  in_t    in_w;
  assign in_w   = in_ch.data;
  // room for the stage-1 item plus a new one
  assign in_ch.ready = (cnt_q + {1'b0, s1_vld_q}) < 2'd2;
  assign accept = in_ch.valid && in_ch.ready;

  // byte step
  always_comb begin
    logic [7:0]  b;
    logic [4:0]  k;
    logic        full;
    logic        done;
    logic        fin;
    logic [31:0] sh;
    logic [32:0] amt;
    logic [1:0]  p;
    logic [1:0]  fm;
    logic [15:0] smp;
    logic [2:0]  align;
    logic [34:0] brate;
    phase_e      ph;
    b = in_w.file_byte;
    phase_d = phase_q; bif_d = bif_q; shift_d = shift_q; chunk_d = chunk_q;
    pos_d = pos_q; riff_end_d = riff_end_q; fmt_code_d = fmt_code_q;
    chans_d = chans_q; hrate_d = hrate_q; hbrate_d = hbrate_q;
    halign_d = halign_q; hbits_d = hbits_q; fseen_d = fseen_q;
    dleft_d = dleft_q; hleft_d = hleft_q; lowb_d = lowb_q;
    s1_vld_d = 1'b0; s1_kind_d = KIND_ERROR; s1_mono_d = 1'b0;
    s1_last_d = 1'b0; s1_ch_d = '0; s1_err_d = ERR_NONE;
    smp = '0; amt = '0; p = '0; fm = '0; align = '0; brate = '0;
    done = 1'b0; fin = 1'b0; full = 1'b0; k = '0; sh = '0;
    if (in_w.start_of_file) begin
      phase_d = PH_RIFF_ID; bif_d = '0; shift_d = '0; chunk_d = '0;
      pos_d = '0; riff_end_d = '0; fmt_code_d = '0; chans_d = '0;
      hrate_d = '0; hbrate_d = '0; halign_d = '0; hbits_d = '0;
      fseen_d = 1'b0; dleft_d = '0; hleft_d = '0; lowb_d = '0;
    end
    ph = phase_d;
    if (accept && ph <= PH_SAMPLES) begin
      if (pos_d != 32'hFFFF_FFFF) pos_d = pos_d + 32'd1;
      if (ph == PH_SAMPLES) begin
        fm = (chans_d == 16'd1) ? 2'd1 : 2'd3;
        p = bif_d[1:0] & fm;
        if (dleft_d != '0) dleft_d = dleft_d - 32'd1;
        if (!p[0]) lowb_d = b;
        else begin
          smp = {b, lowb_d};
          if (p == fm) begin
            s1_vld_d = 1'b1; s1_kind_d = KIND_FRAME;
            s1_mono_d = (fm == 2'd1);
            s1_last_d = (dleft_d == '0);
          end else hleft_d = smp;
        end
        bif_d = {3'b0, (p + 2'd1) & fm};
        if (dleft_d == '0) phase_d = PH_IDLE;
      end else begin
        sh = {b, shift_d[31:8]};
        shift_d = sh;
        k = bif_d;
        full = (k == 5'd3);
        unique case (ph)
          PH_RIFF_ID: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              if (sh != TAG_RIFF) begin done = 1'b1; s1_err_d = ERR_RIFF_WAVE; end
              else phase_d = PH_RIFF_SIZE;
            end
          end
          PH_RIFF_SIZE: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              riff_end_d = {1'b0, sh} + 33'd8;
              phase_d = PH_WAVE_ID;
            end
          end
          PH_WAVE_ID: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              if (sh != TAG_WAVE) begin done = 1'b1; s1_err_d = ERR_RIFF_WAVE; end
              else if (riff_end_d < 33'd12 || riff_end_d > {1'b0, file_size_q}) begin
                done = 1'b1; s1_err_d = ERR_RIFF_SIZE;
              end else phase_d = PH_CHUNK_ID;
            end
          end
          PH_CHUNK_ID: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              if (sh == TAG_FMT)       phase_d = PH_FMT_SIZE;
              else if (sh == TAG_DATA) phase_d = PH_DATA_SIZE;
              else                     phase_d = PH_OTHER_SIZE;
            end
          end
          PH_FMT_SIZE: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              if (sh < 32'd16) begin done = 1'b1; s1_err_d = ERR_SHORT_FMT; end
              else begin
                chunk_d = {1'b0, sh - 32'd16} + {32'b0, sh[0]};
                phase_d = PH_FMT_BODY;
              end
            end
          end
          PH_DATA_SIZE: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              done = 1'b1;
              align = (chans_d == 16'd1) ? 3'd2 : 3'd4;
              brate = {3'b0, hrate_d} * {32'b0, align};
              if (!fseen_d) s1_err_d = ERR_DATA_EARLY;
              else if (fmt_code_d != 16'd1) s1_err_d = ERR_NOT_PCM;
              else if (hrate_d != {13'b0, exp_rate_q}) s1_err_d = ERR_RATE;
              else if (hbits_d != 16'd16) s1_err_d = ERR_BITS;
              else if (chans_d != 16'd1 && chans_d != 16'd2) s1_err_d = ERR_CHANNELS;
              else if (halign_d != {13'b0, align} || {3'b0, hbrate_d} != brate)
                s1_err_d = ERR_ALIGN;
              else if (sh == '0 || sh[0] || (align == 3'd4 && sh[1]))
                s1_err_d = ERR_DATA_SIZE;
              else if ({1'b0, pos_d} + {1'b0, sh} > {1'b0, file_size_q})
                s1_err_d = ERR_TRUNCATED;
              else begin
                dleft_d = sh; bif_d = '0; phase_d = PH_SAMPLES;
                s1_vld_d = 1'b1; s1_kind_d = KIND_HEADER; s1_ch_d = chans_d[1:0];
              end
            end
          end
          PH_OTHER_SIZE: begin
            bif_d = full ? 5'd0 : k + 5'd1;
            if (full) begin
              chunk_d = {1'b0, sh} + {32'b0, sh[0]};
              if ({1'b0, pos_d} + chunk_d > {1'b0, file_size_q}) begin
                done = 1'b1; s1_err_d = ERR_SKIP_END;
              end else begin
                bif_d = '0;
                phase_d = (chunk_d == '0) ? PH_CHUNK_ID : PH_SKIP;
              end
            end
          end
          PH_FMT_BODY: begin
            bif_d = k + 5'd1;
            if (k == 5'd1) fmt_code_d = sh[31:16];
            else if (k == 5'd3) chans_d = sh[31:16];
            else if (k == 5'd7) hrate_d = sh;
            else if (k == 5'd11) hbrate_d = sh;
            else if (k == 5'd13) halign_d = sh[31:16];
            else if (k >= 5'd15) begin
              hbits_d = sh[31:16];
              if ({1'b0, pos_d} + chunk_d > {1'b0, file_size_q}) begin
                done = 1'b1; s1_err_d = ERR_SKIP_END;
              end else begin
                fseen_d = 1'b1; bif_d = '0;
                phase_d = (chunk_d == '0) ? PH_CHUNK_ID : PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (chunk_d != '0) chunk_d = chunk_d - 33'd1;
            if (chunk_d == '0) phase_d = PH_CHUNK_ID;
          end
          default: ;
        endcase
        fin = done && s1_kind_d == KIND_HEADER;
        if (done && !fin) begin
          s1_vld_d = 1'b1; s1_kind_d = KIND_ERROR; phase_d = PH_IDLE;
        end else if (!done && pos_d == file_size_q) begin
          s1_vld_d = 1'b1; s1_kind_d = KIND_ERROR; s1_err_d = ERR_MISSING;
          phase_d = PH_IDLE;
        end
      end
    end
    s1_pr_d = $signed({{17{smp[15]}}, smp}) * $signed({17'b0, volume_q});
    s1_pl_d = $signed({{17{hleft_d[15]}}, hleft_d}) * $signed({17'b0, volume_q});
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF_ID; bif_q <= '0; shift_q <= '0; chunk_q <= '0;
      pos_q <= '0; riff_end_q <= '0; fmt_code_q <= '0; chans_q <= '0;
      hrate_q <= '0; hbrate_q <= '0; halign_q <= '0; hbits_q <= '0;
      fseen_q <= 1'b0; dleft_q <= '0; hleft_q <= '0; lowb_q <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (accept) begin
        phase_q <= phase_d; bif_q <= bif_d; shift_q <= shift_d; chunk_q <= chunk_d;
        pos_q <= pos_d; riff_end_q <= riff_end_d; fmt_code_q <= fmt_code_d;
        chans_q <= chans_d; hrate_q <= hrate_d; hbrate_q <= hbrate_d;
        halign_q <= halign_d; hbits_q <= hbits_d; fseen_q <= fseen_d;
        dleft_q <= dleft_d; hleft_q <= hleft_d; lowb_q <= lowb_d;
      end
    end
  end

  // stage-1 payload
  always_ff @(posedge clk_i) begin
    s1_kind_q <= s1_kind_d; s1_mono_q <= s1_mono_d; s1_last_q <= s1_last_d;
    s1_ch_q <= s1_ch_d; s1_err_q <= s1_err_d; s1_pl_q <= s1_pl_d; s1_pr_q <= s1_pr_d;
  end

  // scaling and queue write
  out_t res;
  always_comb begin
    res = '0;
    res.result_kind = s1_kind_q;
    if (s1_kind_q == KIND_FRAME) begin
      res.right_sample = q15_sat(s1_pr_q);
      res.left_sample  = s1_mono_q ? res.right_sample : q15_sat(s1_pl_q);
      res.last_frame   = s1_last_q;
    end else if (s1_kind_q == KIND_HEADER) res.channel_count = s1_ch_q;
    else res.error_code = s1_err_q;
  end

  logic pop;
  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (cnt_q != 2'd0);
  assign out_ch.data  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) fifo_q[wr_ptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (s1_vld_q) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, s1_vld_q} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cnt_q == 2'd2 && s1_vld_q)) else $error("output queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> cnt_q != 2'd0) else $error("result lost");
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_IDLE && !in_w.start_of_file) |=> !s1_vld_q)
    else $error("result from idle parser");
`endif

endmodule

// File: tb/tb_wav_pcm_stream_decoder.sv
// Testbench for wav_pcm_stream_decoder: WAV byte stream stimulus, decode prediction, result check.
module tb_wav_pcm_stream_decoder;
  import wav_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned TargetBytes   = 1600;
  localparam logic [31:0] TagList       = 32'h5453_494C;

  typedef enum int {
    FM_GOOD, FM_BAD_RIFF, FM_BAD_WAVE, FM_RIFF_SIZE, FM_SHORT_FMT, FM_SKIP_END,
    FM_NOT_PCM, FM_RATE, FM_BITS, FM_CHANNELS, FM_ALIGN, FM_DATA_SIZE,
    FM_TRUNC, FM_DATA_EARLY, FM_MISSING, FM_FLIP, FM_NOISE
  } file_mode_e;

  // Decode predictor plus queue of expected results
  class frame_scoreboard;
    out_t        pending_results[$];
    int unsigned mismatches;
    // register copies
    logic [31:0] file_size;
    logic [18:0] want_rate;
    logic [15:0] volume;
    // parse state
    phase_e      phase;
    logic [4:0]  bif;
    logic [31:0] shift;
    longint unsigned chunk_left;
    logic [31:0] pos;
    longint unsigned riff_end;
    logic [15:0] fmt_code, chans, balign, bits;
    logic [31:0] rate, byte_rate, data_left;
    bit          fmt_seen;
    logic [15:0] held_left;
    logic [7:0]  low_byte;

    function new();
      file_size = '0;
      want_rate = 19'd44100;
      volume    = 16'd32768;
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = PH_RIFF_ID; bif = '0; shift = '0; chunk_left = 0; pos = '0;
      riff_end = 0; fmt_code = '0; chans = '0; rate = '0; byte_rate = '0;
      balign = '0; bits = '0; fmt_seen = 0; data_left = '0; held_left = '0;
      low_byte = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_FILE_SIZE) file_size = val;
      else if (idx == CFG_RATE) want_rate = val[18:0];
      else if (idx == CFG_VOLUME) volume = val[15:0];
    endfunction

    function bit fault(err_e code, output out_t r);
      phase = PH_IDLE;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      return 1;
    endfunction

    function bit past_end(longint unsigned amt);
      return (longint'({32'b0, pos}) + amt) > longint'({32'b0, file_size});
    endfunction

    // Q15 gain, truncation toward zero, 16-bit saturation
    function logic [15:0] scale(logic [15:0] raw);
      longint s, q;
      s = longint'($signed(raw));
      q = (s * longint'({48'b0, volume})) / 32768;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void skip_setup();
      bif = '0;
      phase = (chunk_left == 0) ? PH_CHUNK_ID : PH_SKIP;
    endfunction

    function bit data_header(logic [31:0] size, output out_t r);
      logic [31:0] align;
      if (!fmt_seen) return fault(ERR_DATA_EARLY, r);
      if (fmt_code != 16'd1) return fault(ERR_NOT_PCM, r);
      if (rate != {13'b0, want_rate}) return fault(ERR_RATE, r);
      if (bits != 16'd16) return fault(ERR_BITS, r);
      if (chans != 16'd1 && chans != 16'd2) return fault(ERR_CHANNELS, r);
      align = {16'b0, chans} * 2;
      if ({16'b0, balign} != align ||
          longint'({32'b0, byte_rate}) != longint'({32'b0, rate}) * longint'(align))
        return fault(ERR_ALIGN, r);
      if (size == 0 || (size % align) != 0) return fault(ERR_DATA_SIZE, r);
      if (past_end({32'b0, size})) return fault(ERR_TRUNCATED, r);
      data_left = size;
      bif = '0;
      phase = PH_SAMPLES;
      r = '0;
      r.result_kind   = KIND_HEADER;
      r.channel_count = chans[1:0];
      return 1;
    endfunction

    function bit take_sample(logic [7:0] b, output out_t r);
      logic [1:0]  mask, p;
      logic [15:0] smp, right;
      bit          got;
      got = 0;
      r = '0;
      mask = (chans == 16'd1) ? 2'd1 : 2'd3;
      p = bif[1:0] & mask;
      if (data_left != 0) data_left--;
      if (!p[0]) begin
        low_byte = b;
      end else begin
        smp = {b, low_byte};
        if (p == mask) begin
          right = scale(smp);
          r.result_kind  = KIND_FRAME;
          r.right_sample = right;
          r.left_sample  = (mask == 2'd1) ? right : scale(held_left);
          r.last_frame   = (data_left == 0);
          got = 1;
        end else begin
          held_left = smp;
        end
      end
      bif = {3'b0, (p + 2'd1) & mask};
      if (data_left == 0) phase = PH_IDLE;
      return got;
    endfunction

    // One input byte through the parser; returns 1 when a result is due
    function bit decode_byte(logic [7:0] b, bit sof, output out_t r);
      logic [4:0]  k;
      logic [31:0] tmp;
      bit          full;
      r = '0;
      if (sof) clear_parse();
      if (phase == PH_IDLE) return 0;
      if (pos != '1) pos++;
      if (phase == PH_SAMPLES) return take_sample(b, r);
      shift = {b, shift[31:8]};
      k = bif;
      full = (k == 5'd3);
      case (phase)
        PH_RIFF_ID: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) begin
            if (shift != TAG_RIFF) return fault(ERR_RIFF_WAVE, r);
            phase = PH_RIFF_SIZE;
          end
        end
        PH_RIFF_SIZE: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) begin
            riff_end = longint'({32'b0, shift}) + 8;
            phase = PH_WAVE_ID;
          end
        end
        PH_WAVE_ID: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) begin
            if (shift != TAG_WAVE) return fault(ERR_RIFF_WAVE, r);
            if (riff_end < 12 || riff_end > longint'({32'b0, file_size}))
              return fault(ERR_RIFF_SIZE, r);
            phase = PH_CHUNK_ID;
          end
        end
        PH_CHUNK_ID: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) begin
            if (shift == TAG_FMT) phase = PH_FMT_SIZE;
            else if (shift == TAG_DATA) phase = PH_DATA_SIZE;
            else phase = PH_OTHER_SIZE;
          end
        end
        PH_FMT_SIZE: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) begin
            if (shift < 32'd16) return fault(ERR_SHORT_FMT, r);
            tmp = shift - 32'd16;
            chunk_left = longint'({32'b0, tmp}) + shift[0];
            phase = PH_FMT_BODY;
          end
        end
        PH_DATA_SIZE: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) return data_header(shift, r);
        end
        PH_OTHER_SIZE: begin
          bif = full ? 5'd0 : k + 5'd1;
          if (full) begin
            chunk_left = longint'({32'b0, shift}) + shift[0];
            if (past_end(chunk_left)) return fault(ERR_SKIP_END, r);
            skip_setup();
          end
        end
        PH_FMT_BODY: begin
          bif = k + 5'd1;
          if (k == 5'd1) fmt_code = shift[31:16];
          else if (k == 5'd3) chans = shift[31:16];
          else if (k == 5'd7) rate = shift;
          else if (k == 5'd11) byte_rate = shift;
          else if (k == 5'd13) balign = shift[31:16];
          else if (k >= 5'd15) begin
            bits = shift[31:16];
            if (past_end(chunk_left)) return fault(ERR_SKIP_END, r);
            fmt_seen = 1;
            skip_setup();
          end
        end
        default: begin
          if (chunk_left != 0) chunk_left--;
          if (chunk_left == 0) phase = PH_CHUNK_ID;
        end
      endcase
      if (pos == file_size) return fault(ERR_MISSING, r);
      return 0;
    endfunction

    function void note_byte(logic [7:0] b, bit sof);
      out_t r;
      if (decode_byte(b, sof, r)) pending_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d err=%0d", got.result_kind, got.error_code);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind || got.left_sample !== want.left_sample ||
          got.right_sample !== want.right_sample || got.last_frame !== want.last_frame ||
          got.channel_count !== want.channel_count || got.error_code !== want.error_code)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp kind=%0d l=%h r=%h last=%0d ch=%0d err=%0d",
                    " | got kind=%0d l=%h r=%h last=%0d ch=%0d err=%0d"},
                   want.result_kind, want.left_sample, want.right_sample, want.last_frame,
                   want.channel_count, want.error_code, got.result_kind, got.left_sample,
                   got.right_sample, got.last_frame, got.channel_count, got.error_code);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  wav_stream_if #(.W($bits(in_t)))  in_ch ();
  wav_stream_if #(.W($bits(out_t))) out_ch ();

  wav_pcm_stream_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  frame_scoreboard sb;
  logic [7:0]  file_bytes[$];
  int unsigned bytes_sent;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  bit          hold_done;
  int unsigned stall_cycles;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    sb = new();
    cfg_we = 1'b0; cfg_idx = CFG_FILE_SIZE; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
    hold_req = 0; hold_done = 0;
    src_idle_pct = 21; snk_idle_pct = 61;
    rst_ni = 1'b0;
  end

  // Receiver: random stalls, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      out_ch.ready = 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      hold_req = 0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_t'(out_ch.data));
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WatchdogLimit) begin
      $display("FAIL wav_pcm_stream_decoder");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // One byte transaction with random lead-in gap; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit sof);
    in_t item;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    item.file_byte = b;
    item.start_of_file = sof;
    in_ch.valid = 1'b1;
    in_ch.data = item;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_byte(b, sof);
    bytes_sent++;
    @(negedge clk_i);
    // idle profile by progress
    if (bytes_sent < TargetBytes / 3) begin
      src_idle_pct = 21; snk_idle_pct = 61;
    end else if (bytes_sent < 2 * TargetBytes / 3) begin
      src_idle_pct = 61; snk_idle_pct = 21;
    end else begin
      src_idle_pct = 0; snk_idle_pct = 0;
    end
    if (!hold_done && bytes_sent >= TargetBytes / 2) begin
      hold_done = 1;
      hold_req = 1;
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic push32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic push16(input logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endtask

  task automatic push_samples(input int unsigned n);
    logic [15:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      s = 16'($urandom());
      if ($urandom_range(7) == 0)
        case ($urandom_range(3))
          0: s = 16'h7FFF;
          1: s = 16'h8000;
          2: s = 16'h0000;
          default: s = 16'hFFFF;
        endcase
      push16(s);
    end
  endtask

  // Build a WAV image in file_bytes, broken as the mode says
  task automatic build_file(input file_mode_e m, input int unsigned chans,
                            input int unsigned frames, output logic [31:0] fsize,
                            output logic [18:0] cfg_rate);
    int unsigned rate, align, fsz, junk, total;
    logic [31:0] riff_field;
    file_bytes.delete();
    rate = $urandom_range(1, 384000);
    if ($urandom_range(7) == 0) rate = ($urandom_range(1)) ? 1 : 384000;
    align = chans * 2;
    push32(TAG_RIFF);
    push32(32'd0);
    push32(TAG_WAVE);
    if (m == FM_SKIP_END) begin
      push32(TagList);
      push32(32'd5000);
    end else if ($urandom_range(1)) begin
      junk = $urandom_range(0, 5);
      push32(TagList);
      push32(junk);
      repeat (junk + junk % 2) file_bytes.push_back(8'($urandom()));
    end
    if (m == FM_DATA_EARLY) begin
      push32(TAG_DATA);
      push32(frames * align);
      push_samples(frames * chans);
    end
    fsz = (m == FM_SHORT_FMT) ? 14 : 16 + $urandom_range(0, 3);
    push32(TAG_FMT);
    push32(fsz);
    push16((m == FM_NOT_PCM) ? 16'd3 : 16'd1);
    push16((m == FM_CHANNELS) ? (($urandom_range(1)) ? 16'd0 : 16'd3) : chans[15:0]);
    push32(rate);
    push32(rate * align + ((m == FM_ALIGN) ? 1 : 0));
    push16(align[15:0]);
    push16((m == FM_BITS) ? 16'd8 : 16'd16);
    // body tail and pad only exist for a full-length fmt chunk
    if (fsz >= 16) repeat (fsz - 16 + fsz % 2) file_bytes.push_back(8'($urandom()));
    if (m != FM_MISSING && m != FM_DATA_EARLY) begin
      push32(TAG_DATA);
      push32(frames * align + ((m == FM_DATA_SIZE) ? 1 : 0));
      push_samples(frames * chans);
    end
    total = file_bytes.size();
    fsize = total;
    riff_field = total - 8;
    if (m == FM_RIFF_SIZE) riff_field = 32'd2;
    if (m == FM_TRUNC) begin
      fsize = total - 1;
      riff_field = total - 9;
    end
    for (int i = 0; i < 4; i++) file_bytes[4 + i] = riff_field[8*i +: 8];
    cfg_rate = 19'(rate);
    if (m == FM_RATE) cfg_rate = 19'((rate == 384000) ? rate - 1 : rate + 1);
    if (m == FM_BAD_RIFF) file_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(7));
    if (m == FM_BAD_WAVE) file_bytes[$urandom_range(8, 11)] ^= 8'(1 << $urandom_range(7));
    if (m == FM_FLIP) file_bytes[$urandom_range(0, total - 1)] = 8'($urandom());
    if (m == FM_NOISE) begin
      file_bytes.delete();
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom()));
      fsize = $urandom_range(0, 20);
    end
    if (m != FM_MISSING) repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom()));
  endtask

  // Configure while idle, then stream one file
  task automatic play_file(input file_mode_e m, input int unsigned chans,
                           input int unsigned frames, input logic [15:0] vol,
                           input bit size_override, input logic [31:0] size_val);
    logic [31:0] fsize;
    logic [18:0] rate;
    build_file(m, chans, frames, fsize, rate);
    if (size_override) fsize = size_val;
    drain();
    write_reg(CFG_FILE_SIZE, fsize);
    write_reg(CFG_RATE, {13'b0, rate});
    write_reg(CFG_VOLUME, {16'b0, vol});
    foreach (file_bytes[i])
      send_byte(file_bytes[i],
                (i == 0) ? 1'b1 : ((m == FM_NOISE) ? 1'($urandom_range(1)) : 1'b0));
  endtask

  initial begin
    file_mode_e  m;
    logic [15:0] vol;
    int unsigned pick;
    bytes_sent = 0;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every error path once, unity and zero gain, file size extremes
    play_file(FM_GOOD, 1, 2, 16'd32768, 0, '0);
    play_file(FM_GOOD, 2, 2, 16'd0, 0, '0);
    play_file(FM_GOOD, 2, 1, 16'd16384, 1, 32'hFFFF_FFFF);
    play_file(FM_GOOD, 1, 1, 16'd32768, 1, 32'd0);
    for (int i = FM_BAD_RIFF; i <= FM_DATA_EARLY + 1; i++) begin
      m = file_mode_e'(i);
      play_file(m, 1 + i % 2, 1, 16'd32768, 0, '0);
    end

    // Random files, mostly well formed
    while (bytes_sent < TargetBytes) begin
      pick = $urandom_range(99);
      if (pick < 65) m = FM_GOOD;
      else m = file_mode_e'($urandom_range(FM_BAD_RIFF, FM_NOISE));
      case ($urandom_range(3))
        0: vol = 16'd32768;
        1: vol = 16'd0;
        default: vol = 16'($urandom_range(0, 32768));
      endcase
      play_file(m, $urandom_range(1, 2),
                ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 12), vol, 0, '0);
    end

    drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("PASS wav_pcm_stream_decoder");
    end else begin
      $display("FAIL wav_pcm_stream_decoder");
    end
    $finish;
  end

endmodule
